[src/vidx_pkg.sv]
// Package for the vector index stream parser.
// Holds the parse phases, result kinds, status codes and the state and result records.
// No dependencies.
`timescale 1ns / 1ps

package vidx_pkg;

  localparam logic [31:0] MagicWord      = 32'h3158_5456;
  localparam logic [2:0]  MaxPrefixGroup = 3'd4;

  typedef enum logic [3:0] {
    PH_MAGIC      = 4'd0,
    PH_DIM        = 4'd1,
    PH_ROWS       = 4'd2,
    PH_COLS       = 4'd3,
    PH_LABELCNT   = 4'd4,
    PH_LABELLEN   = 4'd5,
    PH_LABELBYTE  = 4'd6,
    PH_ENTRYCNT   = 4'd7,
    PH_ROW        = 4'd8,
    PH_COL        = 4'd9,
    PH_PHRASELEN  = 4'd10,
    PH_PHRASEBYTE = 4'd11,
    PH_VEC        = 4'd12,
    PH_IDLE       = 4'd13
  } phase_e;

  typedef enum logic [3:0] {
    KIND_MAGIC      = 4'd0,
    KIND_DIM        = 4'd1,
    KIND_ROWS       = 4'd2,
    KIND_COLS       = 4'd3,
    KIND_LABELCNT   = 4'd4,
    KIND_LABELLEN   = 4'd5,
    KIND_LABELBYTE  = 4'd6,
    KIND_ENTRYCNT   = 4'd7,
    KIND_ROW        = 4'd8,
    KIND_COL        = 4'd9,
    KIND_PHRASELEN  = 4'd10,
    KIND_PHRASEBYTE = 4'd11,
    KIND_VECWORD    = 4'd12,
    KIND_ERROR      = 4'd13
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_MAGIC   = 3'd1,
    ST_TRUNCATED   = 3'd2,
    ST_PREFIX_LONG = 3'd3,
    ST_NEG_COUNT   = 3'd4
  } status_e;

  typedef struct packed {
    phase_e      phase;
    logic [1:0]  byte_in_word;
    logic [31:0] word_gather;
    logic [2:0]  prefix_group;
    logic [31:0] labels_left;
    logic [31:0] entries_left;
    logic [31:0] dimension;
    logic [31:0] string_left;
    logic [31:0] vec_left;
  } state_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] value;
    status_e     status;
    logic        done;
  } result_t;

  localparam state_t StateReset = '{
    phase:        PH_MAGIC,
    byte_in_word: 2'd0,
    word_gather:  32'd0,
    prefix_group: 3'd0,
    labels_left:  32'd0,
    entries_left: 32'd0,
    dimension:    32'd0,
    string_left:  32'd0,
    vec_left:     32'd0
  };

endpackage

[src/vidx_decode.sv]
// Next-state and result logic for one byte of the record stream.
// Purely combinational; uses vidx_pkg.
`timescale 1ns / 1ps

module vidx_decode (
  input  vidx_pkg::state_t  st_i,
  input  logic [7:0]        data_byte_i,
  input  logic              final_byte_i,
  output vidx_pkg::state_t  st_o,
  output logic              have_o,
  output vidx_pkg::result_t res_o
);
  import vidx_pkg::*;

  state_t      nx;
  result_t     res;
  logic        have;
  logic [31:0] word;
  logic [31:0] len_acc;
  logic [4:0]  len_shift;
  logic        is_label;
  logic        label_end;
  logic        phrase_end;
  logic        entry_end;

  always_comb begin
    unique case (st_i.byte_in_word)
      2'd0: word = st_i.word_gather | {24'd0, data_byte_i};
      2'd1: word = st_i.word_gather | {16'd0, data_byte_i, 8'd0};
      2'd2: word = st_i.word_gather | {8'd0, data_byte_i, 16'd0};
      2'd3: word = st_i.word_gather | {data_byte_i, 24'd0};
      default: word = st_i.word_gather;
    endcase
  end

  // Seven bits per prefix byte; anything shifted past bit 31 drops.
  always_comb begin
    unique case (st_i.prefix_group)
      3'd0:    len_shift = 5'd0;
      3'd1:    len_shift = 5'd7;
      3'd2:    len_shift = 5'd14;
      3'd3:    len_shift = 5'd21;
      3'd4:    len_shift = 5'd28;
      default: len_shift = 5'd0;
    endcase
    len_acc = st_i.string_left | ({25'd0, data_byte_i[6:0]} << len_shift);
  end

  always_comb begin
    nx         = st_i;
    res        = '{kind: KIND_MAGIC, value: 32'd0, status: ST_OK, done: 1'b0};
    have       = 1'b0;
    label_end  = 1'b0;
    phrase_end = 1'b0;
    entry_end  = 1'b0;
    is_label   = (st_i.phase == PH_LABELLEN) || (st_i.phase == PH_LABELBYTE);

    unique case (st_i.phase)
      PH_MAGIC, PH_DIM, PH_ROWS, PH_COLS, PH_LABELCNT, PH_ENTRYCNT,
      PH_ROW, PH_COL, PH_VEC: begin
        if (st_i.byte_in_word == 2'd3) begin
          nx.byte_in_word = 2'd0;
          nx.word_gather  = 32'd0;
          have            = 1'b1;
          res.value       = word;
          unique case (st_i.phase)
            PH_MAGIC: begin
              if (word != MagicWord) begin
                res.kind   = KIND_ERROR;
                res.value  = 32'd0;
                res.status = ST_BAD_MAGIC;
                nx.phase   = PH_IDLE;
              end else begin
                res.kind = KIND_MAGIC;
                nx.phase = PH_DIM;
              end
            end
            PH_DIM: begin
              nx.dimension = word;
              res.kind     = KIND_DIM;
              nx.phase     = PH_ROWS;
            end
            PH_ROWS: begin
              res.kind = KIND_ROWS;
              nx.phase = PH_COLS;
            end
            PH_COLS: begin
              res.kind = KIND_COLS;
              nx.phase = PH_LABELCNT;
            end
            PH_LABELCNT: begin
              if (word[31]) begin
                res.kind   = KIND_ERROR;
                res.value  = 32'd0;
                res.status = ST_NEG_COUNT;
                nx.phase   = PH_IDLE;
              end else begin
                nx.labels_left = word;
                res.kind       = KIND_LABELCNT;
                if (word == 32'd0) begin
                  nx.phase = PH_ENTRYCNT;
                end else begin
                  nx.prefix_group = 3'd0;
                  nx.string_left  = 32'd0;
                  nx.phase        = PH_LABELLEN;
                end
              end
            end
            PH_ENTRYCNT: begin
              if (word[31]) begin
                res.kind   = KIND_ERROR;
                res.value  = 32'd0;
                res.status = ST_NEG_COUNT;
                nx.phase   = PH_IDLE;
              end else begin
                nx.entries_left = word;
                res.kind        = KIND_ENTRYCNT;
                if (word == 32'd0) begin
                  res.done = 1'b1;
                  nx.phase = PH_IDLE;
                end else begin
                  nx.phase = PH_ROW;
                end
              end
            end
            PH_ROW: begin
              res.kind = KIND_ROW;
              nx.phase = PH_COL;
            end
            PH_COL: begin
              res.kind        = KIND_COL;
              nx.prefix_group = 3'd0;
              nx.string_left  = 32'd0;
              nx.phase        = PH_PHRASELEN;
            end
            default: begin
              res.kind    = KIND_VECWORD;
              nx.vec_left = st_i.vec_left - 32'd1;
              entry_end   = (st_i.vec_left == 32'd1);
            end
          endcase
        end else begin
          nx.byte_in_word = st_i.byte_in_word + 2'd1;
          nx.word_gather  = word;
        end
      end

      PH_LABELLEN, PH_PHRASELEN: begin
        nx.string_left = len_acc;
        if (data_byte_i[7]) begin
          if (st_i.prefix_group >= MaxPrefixGroup) begin
            have       = 1'b1;
            res.kind   = KIND_ERROR;
            res.status = ST_PREFIX_LONG;
            nx.phase   = PH_IDLE;
          end else begin
            nx.prefix_group = st_i.prefix_group + 3'd1;
          end
        end else begin
          nx.prefix_group = 3'd0;
          have            = 1'b1;
          res.kind        = is_label ? KIND_LABELLEN : KIND_PHRASELEN;
          res.value       = len_acc;
          if (len_acc == 32'd0) begin
            label_end  = is_label;
            phrase_end = !is_label;
          end else begin
            nx.phase = is_label ? PH_LABELBYTE : PH_PHRASEBYTE;
          end
        end
      end

      PH_LABELBYTE, PH_PHRASEBYTE: begin
        have           = 1'b1;
        res.kind       = is_label ? KIND_LABELBYTE : KIND_PHRASEBYTE;
        res.value      = {24'd0, data_byte_i};
        nx.string_left = st_i.string_left - 32'd1;
        if (st_i.string_left == 32'd1) begin
          label_end  = is_label;
          phrase_end = !is_label;
        end
      end

      default: begin
      end
    endcase

    if (label_end) begin
      nx.labels_left = st_i.labels_left - 32'd1;
      if (st_i.labels_left == 32'd1) begin
        nx.phase = PH_ENTRYCNT;
      end else begin
        nx.prefix_group = 3'd0;
        nx.string_left  = 32'd0;
        nx.phase        = PH_LABELLEN;
      end
    end

    // Positive dimension: vector words follow the phrase.
    if (phrase_end) begin
      if ((st_i.dimension != 32'd0) && !st_i.dimension[31]) begin
        nx.vec_left     = st_i.dimension;
        nx.byte_in_word = 2'd0;
        nx.word_gather  = 32'd0;
        nx.phase        = PH_VEC;
      end else begin
        entry_end = 1'b1;
      end
    end

    if (entry_end) begin
      nx.entries_left = st_i.entries_left - 32'd1;
      if (st_i.entries_left == 32'd1) begin
        res.done = 1'b1;
        nx.phase = PH_IDLE;
      end else begin
        nx.phase = PH_ROW;
      end
    end

    // Last byte of the blob: flag an unfinished structure, then re-arm.
    if (final_byte_i) begin
      if (nx.phase != PH_IDLE) begin
        have       = 1'b1;
        res.kind   = KIND_ERROR;
        res.value  = 32'd0;
        res.status = (nx.phase == PH_MAGIC) ? ST_BAD_MAGIC : ST_TRUNCATED;
        res.done   = 1'b0;
      end
      nx = StateReset;
    end
  end

  assign st_o   = nx;
  assign have_o = have;
  assign res_o  = res;

endmodule

[src/vidx_out_buf.sv]
// Two-entry result buffer: output register plus skid register.
// Uses vidx_pkg for the result record.
`timescale 1ns / 1ps

module vidx_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  vidx_pkg::result_t res_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output vidx_pkg::result_t res_o
);
  import vidx_pkg::*;

  logic    out_valid_q;
  logic    skid_valid_q;
  result_t out_q;
  result_t skid_q;
  logic    out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      // Drain the skid first; push cannot happen while it is occupied.
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push_i;
      end
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : res_i;
    end else if (push_i) begin
      skid_q <= res_i;
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

[src/vector_index_stream_parser.sv]
// Top level of the vector index stream parser.
// Depends on vidx_pkg, vidx_decode and vidx_out_buf.
`timescale 1ns / 1ps

// Usage:
//   Input channel: one blob byte per beat on data_byte_i, final_byte_i set on
//   the last byte. A beat is taken at a rising edge with in_valid_i high and
//   in_stall_o low.
//   Output channel: one decoded field per beat (kind, value, status, done),
//   taken at an edge with out_valid_o high and out_stall_i low. A byte yields
//   zero or one field; a word field appears on its fourth byte.
//   Throughput: one byte per cycle while in_stall_o is low; the per-byte
//   decode is short combinational logic between the parse state register
//   and the output register, or the skid register while the output stalls.
//   Stall: the output register plus a skid register hold up to two fields;
//   in_stall_o rises only while the skid register is occupied, so input keeps
//   flowing until a field has to wait in the skid register.
//   Reset: the parser waits for the magic word with both result registers
//   empty. A beat with final_byte_i set re-arms the parser for the magic word.
//   Errors end the structure; later bytes give nothing until the final byte.

module vector_index_stream_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        final_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  field_kind_o,
  output logic [31:0] field_value_o,
  output logic [2:0]  status_o,
  output logic        blob_done_o
);
  import vidx_pkg::*;

  state_t  st_q;
  state_t  st_d;
  logic    have;
  result_t res;
  result_t res_out;
  logic    in_accept;
  logic    buf_full;

  assign in_accept = in_valid_i && !buf_full;

  // Decode one byte against the current parse state.
  vidx_decode u_decode (
    .st_i         (st_q),
    .data_byte_i  (data_byte_i),
    .final_byte_i (final_byte_i),
    .st_o         (st_d),
    .have_o       (have),
    .res_o        (res)
  );

  // Advance the parse state only on an accepted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StateReset;
    end else if (in_accept) begin
      st_q <= st_d;
    end
  end

  vidx_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_accept && have),
    .res_i       (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out)
  );

  assign in_stall_o    = buf_full;
  assign field_kind_o  = res_out.kind;
  assign field_value_o = res_out.value;
  assign status_o      = res_out.status;
  assign blob_done_o   = res_out.done;

endmodule

[src/vidx_checker.sv]
// Port-level checks for the vector index stream parser, bound to the top level.
// Depends on vidx_pkg and vector_index_stream_parser.
`timescale 1ns / 1ps

module vidx_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [3:0]  field_kind_o,
  input logic [31:0] field_value_o,
  input logic [2:0]  status_o,
  input logic        blob_done_o
);
  import vidx_pkg::*;

  // Hold a stalled result beat.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(field_kind_o) &&
      $stable(field_value_o) && $stable(status_o) && $stable(blob_done_o))
    else $error("stalled result beat changed");

  // Input back-pressure only while both result registers are full.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  a_error_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (field_kind_o == KIND_ERROR) |->
      (field_value_o == 32'd0) && (status_o != ST_OK) && !blob_done_o)
    else $error("malformed error beat");

  a_ok_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (field_kind_o != KIND_ERROR) |-> (status_o == ST_OK))
    else $error("status set on a field beat");

  // Completion only closes an entry list or an entry.
  a_done_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && blob_done_o |->
      (field_kind_o == KIND_ENTRYCNT) || (field_kind_o == KIND_PHRASELEN) ||
      (field_kind_o == KIND_PHRASEBYTE) || (field_kind_o == KIND_VECWORD))
    else $error("completion on unexpected field kind");

endmodule

bind vector_index_stream_parser vidx_checker u_vidx_checker (.*);

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Testbench for vector_index_stream_parser: a directed byte table, then random blobs.
// Depends on vidx_pkg and the parser RTL; every output beat is checked against DirTab or an in-bench decoder.

module tb;
  import vidx_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned ByteTarget = 1700;
  localparam int unsigned BlobCap    = 160;
  localparam int unsigned HoldCycles = 300;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
    logic       typed;
    result_t    want;
  } beat_t;

  localparam result_t NoField = '{KIND_MAGIC, 32'd0, ST_OK, 1'b0};

  // Typed rows carry the field the parser must produce for that byte.
  localparam beat_t DirTab [27] = '{
    // bad magic, then a final byte that is ignored
    '{8'h00, 1'b0, 1'b0, NoField},
    '{8'h00, 1'b0, 1'b0, NoField},
    '{8'h00, 1'b0, 1'b0, NoField},
    '{8'h00, 1'b0, 1'b1, '{KIND_ERROR, 32'd0, ST_BAD_MAGIC, 1'b0}},
    '{8'hFF, 1'b1, 1'b0, NoField},
    // blob cut short inside the magic word
    '{8'h56, 1'b1, 1'b1, '{KIND_ERROR, 32'd0, ST_BAD_MAGIC, 1'b0}},
    // good magic, all-ones dimension, zero rows, largest positive cols
    '{8'h56, 1'b0, 1'b0, NoField},
    '{8'h54, 1'b0, 1'b0, NoField},
    '{8'h58, 1'b0, 1'b0, NoField},
    '{8'h31, 1'b0, 1'b1, '{KIND_MAGIC, MagicWord, ST_OK, 1'b0}},
    '{8'hFF, 1'b0, 1'b0, NoField},
    '{8'hFF, 1'b0, 1'b0, NoField},
    '{8'hFF, 1'b0, 1'b0, NoField},
    '{8'hFF, 1'b0, 1'b1, '{KIND_DIM, 32'hFFFF_FFFF, ST_OK, 1'b0}},
    '{8'h00, 1'b0, 1'b0, NoField},
    '{8'h00, 1'b0, 1'b0, NoField},
    '{8'h00, 1'b0, 1'b0, NoField},
    '{8'h00, 1'b0, 1'b1, '{KIND_ROWS, 32'd0, ST_OK, 1'b0}},
    '{8'hFF, 1'b0, 1'b0, NoField},
    '{8'hFF, 1'b0, 1'b0, NoField},
    '{8'hFF, 1'b0, 1'b0, NoField},
    '{8'h7F, 1'b0, 1'b1, '{KIND_COLS, 32'h7FFF_FFFF, ST_OK, 1'b0}},
    // negative label count
    '{8'h00, 1'b0, 1'b0, NoField},
    '{8'h00, 1'b0, 1'b0, NoField},
    '{8'h00, 1'b0, 1'b0, NoField},
    '{8'h80, 1'b0, 1'b1, '{KIND_ERROR, 32'd0, ST_NEG_COUNT, 1'b0}},
    '{8'h00, 1'b1, 1'b0, NoField}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        final_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [3:0]  field_kind_o;
  logic [31:0] field_value_o;
  logic [2:0]  status_o;
  logic        blob_done_o;

  vector_index_stream_parser uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .final_byte_i (final_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .field_kind_o (field_kind_o),
    .field_value_o(field_value_o),
    .status_o     (status_o),
    .blob_done_o  (blob_done_o)
  );

  // Decoder state, kept apart from the RTL.
  phase_e      dec_phase;
  logic [1:0]  dec_bsel;
  logic [31:0] dec_gather;
  int unsigned dec_group;
  logic [31:0] dec_labels;
  logic [31:0] dec_entries;
  logic [31:0] dec_dim;
  logic [31:0] dec_strlen;
  logic [31:0] dec_vecs;
  bit          got_field;
  result_t     got;

  result_t     field_q [$];
  logic [7:0]  blob_q [$];
  int unsigned errors;
  int unsigned sent_bytes;
  int unsigned cycles;
  bit          tx_idle;
  bit          rx_idle;
  int unsigned hold_cnt;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("tb failed");
      $finish;
    end
  end

  function automatic void dec_clear();
    dec_phase   = PH_MAGIC;
    dec_bsel    = '0;
    dec_gather  = '0;
    dec_group   = 0;
    dec_labels  = '0;
    dec_entries = '0;
    dec_dim     = '0;
    dec_strlen  = '0;
    dec_vecs    = '0;
  endfunction

  function automatic void emit_field(kind_e k, logic [31:0] v);
    got_field  = 1'b1;
    got.kind   = k;
    got.value  = v;
    got.status = ST_OK;
  endfunction

  function automatic void raise_error(status_e s);
    got_field  = 1'b1;
    got.kind   = KIND_ERROR;
    got.value  = '0;
    got.status = s;
    got.done   = 1'b0;
    dec_phase  = PH_IDLE;
  endfunction

  function automatic void close_blob();
    got.done  = 1'b1;
    dec_phase = PH_IDLE;
  endfunction

  function automatic void open_length(phase_e nxt);
    dec_group  = 0;
    dec_strlen = '0;
    dec_phase  = nxt;
  endfunction

  function automatic void next_entry();
    dec_entries = dec_entries - 32'd1;
    if (dec_entries == 0) close_blob();
    else dec_phase = PH_ROW;
  endfunction

  function automatic void next_label();
    dec_labels = dec_labels - 32'd1;
    if (dec_labels == 0) dec_phase = PH_ENTRYCNT;
    else open_length(PH_LABELLEN);
  endfunction

  // Vector words follow only for a positive dimension.
  function automatic void end_phrase();
    if (dec_dim != 0 && !dec_dim[31]) begin
      dec_vecs   = dec_dim;
      dec_bsel   = '0;
      dec_gather = '0;
      dec_phase  = PH_VEC;
    end else begin
      next_entry();
    end
  endfunction

  function automatic void take_word(logic [31:0] w);
    case (dec_phase)
      PH_MAGIC: begin
        if (w != MagicWord) raise_error(ST_BAD_MAGIC);
        else begin
          emit_field(KIND_MAGIC, w);
          dec_phase = PH_DIM;
        end
      end
      PH_DIM: begin
        dec_dim = w;
        emit_field(KIND_DIM, w);
        dec_phase = PH_ROWS;
      end
      PH_ROWS: begin
        emit_field(KIND_ROWS, w);
        dec_phase = PH_COLS;
      end
      PH_COLS: begin
        emit_field(KIND_COLS, w);
        dec_phase = PH_LABELCNT;
      end
      PH_LABELCNT: begin
        if (w[31]) raise_error(ST_NEG_COUNT);
        else begin
          dec_labels = w;
          emit_field(KIND_LABELCNT, w);
          if (w == 0) dec_phase = PH_ENTRYCNT;
          else open_length(PH_LABELLEN);
        end
      end
      PH_ENTRYCNT: begin
        if (w[31]) raise_error(ST_NEG_COUNT);
        else begin
          dec_entries = w;
          emit_field(KIND_ENTRYCNT, w);
          if (w == 0) close_blob();
          else dec_phase = PH_ROW;
        end
      end
      PH_ROW: begin
        emit_field(KIND_ROW, w);
        dec_phase = PH_COL;
      end
      PH_COL: begin
        emit_field(KIND_COL, w);
        open_length(PH_PHRASELEN);
      end
      default: begin
        emit_field(KIND_VECWORD, w);
        dec_vecs = dec_vecs - 32'd1;
        if (dec_vecs == 0) next_entry();
      end
    endcase
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic fin);
    bit          lbl;
    logic [31:0] w;
    logic [31:0] bits7;
    got_field = 1'b0;
    got       = NoField;
    case (dec_phase)
      PH_MAGIC, PH_DIM, PH_ROWS, PH_COLS, PH_LABELCNT, PH_ENTRYCNT, PH_ROW, PH_COL,
      PH_VEC: begin
        dec_gather = dec_gather | ({24'd0, b} << (8 * dec_bsel));
        if (dec_bsel == 2'd3) begin
          w          = dec_gather;
          dec_bsel   = '0;
          dec_gather = '0;
          take_word(w);
        end else begin
          dec_bsel = dec_bsel + 2'd1;
        end
      end
      PH_LABELLEN, PH_PHRASELEN: begin
        lbl        = (dec_phase == PH_LABELLEN);
        bits7      = {25'd0, b[6:0]};
        // bits shifted past bit 31 drop out
        dec_strlen = dec_strlen | (bits7 << ((7 * dec_group) & 31));
        if (b[7]) begin
          if (dec_group >= MaxPrefixGroup) raise_error(ST_PREFIX_LONG);
          else dec_group = dec_group + 1;
        end else begin
          dec_group = 0;
          emit_field(lbl ? KIND_LABELLEN : KIND_PHRASELEN, dec_strlen);
          if (dec_strlen == 0) begin
            if (lbl) next_label();
            else end_phrase();
          end else begin
            dec_phase = lbl ? PH_LABELBYTE : PH_PHRASEBYTE;
          end
        end
      end
      PH_LABELBYTE, PH_PHRASEBYTE: begin
        lbl = (dec_phase == PH_LABELBYTE);
        emit_field(lbl ? KIND_LABELBYTE : KIND_PHRASEBYTE, {24'd0, b});
        dec_strlen = dec_strlen - 32'd1;
        if (dec_strlen == 0) begin
          if (lbl) next_label();
          else end_phrase();
        end
      end
      default: ;
    endcase
    // A final byte on an open structure replaces any field with an error.
    if (fin) begin
      if (dec_phase != PH_IDLE)
        raise_error(dec_phase == PH_MAGIC ? ST_BAD_MAGIC : ST_TRUNCATED);
      dec_clear();
    end
  endfunction

  // Append to the tail of the byte and field queues.
  function automatic void append_byte(logic [7:0] b);
    blob_q = {blob_q, b};
  endfunction

  function automatic void queue_field(result_t r);
    field_q = {field_q, r};
  endfunction

  // Offer one beat, hold it through stalls, and decode it once taken.
  task automatic send_beat(beat_t s);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    data_byte_i  <= s.data;
    final_byte_i <= s.fin;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_bytes++;
    decode_byte(s.data, s.fin);
    if (s.typed) queue_field(s.want);
    else if (got_field) queue_field(got);
  endtask

  function automatic bit room();
    return blob_q.size() < BlobCap;
  endfunction

  function automatic void put_word(logic [31:0] w);
    for (int i = 0; i < 4; i++) append_byte(w[8*i +: 8]);
  endfunction

  function automatic void put_bytes(int unsigned n);
    for (int unsigned k = 0; k < n && room(); k++) append_byte(8'($urandom));
  endfunction

  // Continuation-coded length, sometimes padded with empty groups, or made too long.
  function automatic void put_len(logic [31:0] v, bit overlong);
    int unsigned groups;
    int unsigned total;
    logic [7:0]  b;
    groups = 1;
    while (groups < 5 && (v >> (7 * groups)) != 0) groups++;
    total = groups;
    if ($urandom_range(0, 4) == 0) total = $urandom_range(groups, 5);
    if (overlong) total = 5;
    for (int unsigned g = 0; g < total; g++) begin
      b = 8'((v >> (7 * g)) & 32'h7F);
      if (g == 4) b[6:4] = 3'($urandom);
      if (g + 1 < total || overlong) b[7] = 1'b1;
      append_byte(b);
    end
  endfunction

  function automatic void build_blob();
    int unsigned pick;
    int unsigned lbls;
    int unsigned ents;
    int unsigned len;
    int unsigned cut;
    int unsigned idx;
    int unsigned nlen;
    int unsigned long_at;
    logic [31:0] magic;
    logic [31:0] dim;
    bit          big;
    bit          neg_lbl;
    bit          neg_ent;
    bit          overlong;
    blob_q.delete();
    pick     = $urandom_range(0, 99);
    big      = (pick >= 84 && pick < 90);
    overlong = (pick >= 76 && pick < 84);
    neg_lbl  = (pick >= 68 && pick < 76) && $urandom_range(0, 1);
    neg_ent  = (pick >= 68 && pick < 76) && !neg_lbl;
    nlen     = 0;
    if (pick >= 95) begin
      put_bytes($urandom_range(1, 8));
    end else begin
      magic = MagicWord;
      if (pick >= 60 && pick < 68) begin
        idx        = $urandom_range(0, 31);
        magic[idx] = ~magic[idx];
      end
      put_word(magic);
      case ($urandom_range(0, 7))
        0:       dim = '0;
        1:       dim = 32'h8000_0000 | $urandom;
        2:       dim = 32'hFFFF_FFFF;
        default: dim = $urandom_range(1, 3);
      endcase
      if (big) dim = $urandom;
      put_word(dim);
      put_word($urandom);
      put_word($urandom);
      lbls = big ? {1'b0, 31'($urandom)} : $urandom_range(overlong ? 1 : 0, 3);
      ents = big ? {1'b0, 31'($urandom)} : $urandom_range(overlong ? 1 : 0, 3);
      long_at = overlong ? $urandom_range(0, lbls) : 32'hFFFF_FFFF;
      if (neg_lbl) begin
        put_word(32'h8000_0000 | $urandom);
        put_bytes($urandom_range(0, 3));
      end else begin
        put_word(lbls);
        for (int unsigned i = 0; i < lbls && room(); i++) begin
          len = big ? $urandom : $urandom_range(0, 4);
          put_len(len, nlen == long_at);
          nlen++;
          put_bytes(len);
        end
        if (neg_ent) begin
          put_word(32'h8000_0000 | $urandom);
          put_bytes($urandom_range(0, 3));
        end else begin
          put_word(ents);
          for (int unsigned i = 0; i < ents && room(); i++) begin
            put_word($urandom);
            put_word($urandom);
            len = big ? $urandom : $urandom_range(0, 5);
            put_len(len, nlen == long_at);
            nlen++;
            put_bytes(len);
            if (dim != 0 && !dim[31])
              for (int unsigned j = 0; j < dim && room(); j++) put_word($urandom);
          end
        end
      end
    end
    // Cut some blobs short; pad others with bytes past the end of the structure.
    if (pick >= 90 && pick < 95 && blob_q.size() > 1) begin
      cut = $urandom_range(1, blob_q.size() - 1);
      while (blob_q.size() > cut) void'(blob_q.pop_back());
    end else if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 3)) append_byte(8'($urandom));
    end
  endfunction

  function automatic void check_field();
    result_t want;
    if (field_q.size() == 0) begin
      $display("%0t: unexpected beat, expected none, actual kind %0d value %h status %0d done %0d",
               $time, field_kind_o, field_value_o, status_o, blob_done_o);
      errors++;
    end else begin
      want = field_q.pop_front();
      if (field_kind_o !== want.kind) begin
        $display("%0t: field_kind expected %0d actual %0d", $time, want.kind, field_kind_o);
        errors++;
      end
      if (field_value_o !== want.value) begin
        $display("%0t: field_value expected %h actual %h", $time, want.value, field_value_o);
        errors++;
      end
      if (status_o !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
        errors++;
      end
      if (blob_done_o !== want.done) begin
        $display("%0t: blob_done expected %0d actual %0d", $time, want.done, blob_done_o);
        errors++;
      end
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_field();
  end

  // Receiver: draw a stall per beat; on request hold off for a long stretch.
  initial begin
    int unsigned wait_n;
    int unsigned holds_done;
    holds_done = 0;
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      wait_n = rx_idle ? $urandom_range(0, 3) : 0;
      if (hold_cnt != holds_done) begin
        wait_n     = HoldCycles;
        holds_done = hold_cnt;
      end
      if (wait_n > 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  initial begin
    beat_t       s;
    int unsigned blob_no;
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    data_byte_i  <= 8'd0;
    final_byte_i <= 1'b0;
    sent_bytes = 0;
    tx_idle    = 1'b1;
    rx_idle    = 1'b1;
    dec_clear();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirTab[i]) send_beat(DirTab[i]);

    blob_no = 0;
    while (sent_bytes < ByteTarget) begin
      build_blob();
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      if (blob_no == 4 || blob_no == 17) hold_cnt++;
      for (int i = 0; i < blob_q.size(); i++) begin
        s.data  = blob_q[i];
        s.fin   = (i == blob_q.size() - 1);
        s.typed = 1'b0;
        s.want  = NoField;
        send_beat(s);
      end
      blob_no++;
    end
    in_valid_i <= 1'b0;

    // Drain, then give any stray beat time to show up.
    while (field_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errors == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule
